// ===== src/grid_ray_dda_column_caster_defines.svh =====
// Assertion helpers used by the controller.
`ifndef GRID_RAY_DDA_COLUMN_CASTER_DEFINES_SVH
`define GRID_RAY_DDA_COLUMN_CASTER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define GRDC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GRDC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/grdc_pkg.sv =====
package grdc_pkg;

   localparam int DIV_W = 40;

   localparam logic [DIV_W-1:0] DELTA_NUM = 40'h40_0000_0000;
   localparam logic [50:0]      DELTA_MAX = {1'b1, 50'b0};
   localparam logic [11:0]      LINE_MAX  = 12'd4095;

   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_X     = 8'h58;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [1:0] CLASS_STAR  = 2'd0;
   localparam logic [1:0] CLASS_CROSS = 2'd1;
   localparam logic [1:0] CLASS_OTHER = 2'd2;
   localparam logic [1:0] CLASS_AMP   = 2'd3;

   localparam logic [2:0] CSR_POS_X         = 3'd0;
   localparam logic [2:0] CSR_POS_Y         = 3'd1;
   localparam logic [2:0] CSR_DIR_X         = 3'd2;
   localparam logic [2:0] CSR_DIR_Y         = 3'd3;
   localparam logic [2:0] CSR_PLANE_X       = 3'd4;
   localparam logic [2:0] CSR_PLANE_Y       = 3'd5;
   localparam logic [2:0] CSR_SCREEN_WIDTH  = 3'd6;
   localparam logic [2:0] CSR_SCREEN_HEIGHT = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAM_WAIT,
      ST_RAY_MUL,
      ST_RAY_ADD,
      ST_DX_START,
      ST_DX_WAIT,
      ST_DY_WAIT,
      ST_SD_INIT,
      ST_STEP,
      ST_ADDR,
      ST_TEST,
      ST_LH_MUL,
      ST_LH_START,
      ST_LH_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CAM_SAVE,
      OP_RAY_MUL,
      OP_RAY_ADD,
      OP_DX_START,
      OP_DX_SAVE,
      OP_DY_SAVE,
      OP_SD_INIT,
      OP_STEP,
      OP_HIT,
      OP_LH_MUL,
      OP_LH_START,
      OP_LH_SAVE,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic req_cast;
      logic div_done;
      logic oob;
      logic wall;
      logic limit;
   } dp_stat_type;

   function automatic logic [1:0] color_of(input logic [7:0] c);
      logic [1:0] r;
      case (c)
         CHAR_STAR: r = CLASS_STAR;
         CHAR_X:    r = CLASS_CROSS;
         CHAR_AMP:  r = CLASS_AMP;
         default:   r = CLASS_OTHER;
      endcase
      return r;
   endfunction

endpackage

// ===== src/grid_ray_dda_column_caster.sv =====
// Grid ray caster: one screen column per cast item.
// Input channel req_*: req_tuser selects the item kind (0 writes one map
// cell, 1 casts one column). A write completes in the cycle of its transfer
// and gives no result. A cast gives one result item on rsp_*.
// Configuration csr_*: plain writes, to be issued only while the block is
// idle and no result is pending.
// A cast takes S DDA steps, S at most 2*MAP_SIZE+132. A wall hit runs four
// passes of the shared bit-serial divider (camera coordinate, two step
// distances, line height); a miss skips the line height pass and ends
// sooner. Each DDA step goes through the states STEP, ADDR and TEST, around
// the registered map read.
// One item is worked on at a time; req_tready is high only when the
// controller is idle. A finished result sits in the output register while
// the next item is accepted; if the receiver stalls, the block holds the
// following result until the register frees.
// Reset restores the configuration defaults and clears the handshake state.
// The map memory is not cleared: every cell that a cast can reach must be
// written first.
module grid_ray_dda_column_caster #(
   parameter int MAP_SIZE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // column[9:0], cell_x[15:10], cell_y[21:16], cell_value[29:22], zero pad
   input  logic [31:0] req_tdata,
   // command[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_column[9:0], hit[10], side[11], wall_char[19:12], color_class[21:20],
   // line_height[33:22], wall_top[44:34], wall_bottom[55:45]
   output logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import grdc_pkg::*;

   op_type      cmd;
   dp_stat_type stat;

   grdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   grdc_dp #(.MAP_SIZE(MAP_SIZE)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );
endmodule

// ===== src/grdc_ram.sv =====
module grdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/grdc_div.sv =====
module grdc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [grdc_pkg::DIV_W-1:0] num,
   input  logic [grdc_pkg::DIV_W-1:0] den,
   output logic                       done,
   output logic [grdc_pkg::DIV_W-1:0] quo
);
   import grdc_pkg::*;

   localparam int CW = $clog2(DIV_W);

   logic [DIV_W-1:0] num_ff, num_in;
   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0] den_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   rem_sh;
   logic             qbit;

   // restoring divider, one quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff[DIV_W-1:0], num_ff[DIV_W-1]};
      qbit    = (rem_sh >= {1'b0, den_ff});
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = num;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[DIV_W-2:0], qbit};
         rem_in = qbit ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quo  = num_ff;
endmodule

// ===== src/grdc_dp.sv =====
module grdc_dp #(
   parameter int MAP_SIZE = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   input  logic [31:0]           req_tdata,
   input  logic [0:0]            req_tuser,
   input  grdc_pkg::op_type      cmd,
   output grdc_pkg::dp_stat_type stat,
   output logic [55:0]           rsp_tdata
);
   import grdc_pkg::*;

   localparam int AW         = $clog2(MAP_SIZE * MAP_SIZE);
   localparam int STEP_LIMIT = 2 * MAP_SIZE + 132;
   localparam int SCW        = $clog2(STEP_LIMIT + 1);

   // configuration
   logic [13:0]        pos_x_ff, pos_y_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic [10:0]        width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= 14'd0;
         pos_y_ff   <= 14'd0;
         dir_x_ff   <= 16'sd16384;
         dir_y_ff   <= 16'sd0;
         plane_x_ff <= 16'sd0;
         plane_y_ff <= 16'sd10813;
         width_ff   <= 11'd80;
         height_ff  <= 11'd24;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POS_X:         pos_x_ff   <= csr_wdata[13:0];
            CSR_POS_Y:         pos_y_ff   <= csr_wdata[13:0];
            CSR_DIR_X:         dir_x_ff   <= csr_wdata;
            CSR_DIR_Y:         dir_y_ff   <= csr_wdata;
            CSR_PLANE_X:       plane_x_ff <= csr_wdata;
            CSR_PLANE_Y:       plane_y_ff <= csr_wdata;
            CSR_SCREEN_WIDTH:  width_ff   <= csr_wdata[10:0];
            CSR_SCREEN_HEIGHT: height_ff  <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // request fields
   logic [9:0] req_column;
   logic [5:0] req_cell_x, req_cell_y;
   logic [7:0] req_cell_value;
   logic       req_cast;

   assign req_column     = req_tdata[9:0];
   assign req_cell_x     = req_tdata[15:10];
   assign req_cell_y     = req_tdata[21:16];
   assign req_cell_value = req_tdata[29:22];
   assign req_cast       = req_tuser[0];

   // working registers
   logic [9:0]         col_ff;
   logic signed [25:0] cam_ff;
   logic signed [41:0] prodx_ff, prody_ff;
   logic signed [28:0] rx_ff, ry_ff;
   logic [50:0]        dx_ff, dy_ff;
   logic [61:0]        sdx_ff, sdy_ff;
   logic signed [10:0] mx_ff, my_ff;
   logic [SCW-1:0]     step_cnt_ff;
   logic               side_ff, hit_ff;
   logic [7:0]         wall_ff;
   logic signed [19:0] num_ff;
   logic [38:0]        hn_ff;
   logic               rdz_ff;
   logic [11:0]        line_ff;
   logic [55:0]        rsp_ff;

   logic [14:0] px, py;
   logic [10:0] w_eff;
   assign px    = {1'b0, pos_x_ff} + 15'd128;
   assign py    = {1'b0, pos_y_ff} + 15'd128;
   assign w_eff = (width_ff == 11'd0) ? 11'd1 : width_ff;

   logic [28:0] neg_rx, neg_ry;
   logic [27:0] mag_rx, mag_ry;
   assign neg_rx = -rx_ff;
   assign neg_ry = -ry_ff;
   assign mag_rx = rx_ff[28] ? neg_rx[27:0] : rx_ff[27:0];
   assign mag_ry = ry_ff[28] ? neg_ry[27:0] : ry_ff[27:0];

   logic [19:0] neg_num, mag_num;
   assign neg_num = -num_ff;
   assign mag_num = num_ff[19] ? neg_num : num_ff;

   // shared divider
   logic             div_start, div_done;
   logic [DIV_W-1:0] div_num, div_den, div_quo;

   always_comb begin
      div_start = 1'b0;
      div_num   = DELTA_NUM;
      div_den   = DIV_W'(mag_rx);
      case (cmd)
         OP_LOAD: begin
            div_start = req_cast;
            div_num   = DIV_W'({req_column, 15'b0});
            div_den   = DIV_W'(w_eff);
         end
         OP_DX_START: div_start = 1'b1;
         OP_DX_SAVE: begin
            div_start = 1'b1;
            div_den   = DIV_W'(mag_ry);
         end
         OP_LH_START: begin
            div_start = 1'b1;
            div_num   = DIV_W'(hn_ff);
            div_den   = DIV_W'({mag_num, 6'b0});
         end
         default: ;
      endcase
   end

   grdc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // map memory
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_rdata;

   assign ram_we    = (cmd == OP_LOAD) && !req_cast &&
                      (int'(req_cell_x) < MAP_SIZE) && (int'(req_cell_y) < MAP_SIZE);
   assign ram_waddr = AW'(int'(req_cell_y) * MAP_SIZE + int'(req_cell_x));
   assign ram_raddr = AW'(int'(my_ff[9:0]) * MAP_SIZE + int'(mx_ff[9:0]));

   grdc_ram #(.WIDTH(8), .DEPTH(MAP_SIZE * MAP_SIZE)) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_cell_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // combinational helpers
   logic signed [41:0] tx, ty;
   logic [8:0]         wfx, wfy;
   logic [59:0]        mulx, muly;
   logic signed [10:0] m_sel;
   logic [14:0]        p_sel;
   logic               neg_sel;
   logic [27:0]        mag_sel;
   logic signed [19:0] m_ext, num_calc;
   logic [11:0]        line_calc;
   logic signed [12:0] dtop, dtop1;
   logic [10:0]        top_v, top_c, bot_c;
   logic [13:0]        bsum;
   logic [12:0]        bv;

   always_comb begin
      // truncate toward zero on the divide by 16384
      tx   = (prodx_ff + (prodx_ff[41] ? 42'sd16383 : 42'sd0)) >>> 14;
      ty   = (prody_ff + (prody_ff[41] ? 42'sd16383 : 42'sd0)) >>> 14;
      wfx  = rx_ff[28] ? {1'b0, px[7:0]} : (9'd256 - {1'b0, px[7:0]});
      wfy  = ry_ff[28] ? {1'b0, py[7:0]} : (9'd256 - {1'b0, py[7:0]});
      mulx = wfx * dx_ff;
      muly = wfy * dy_ff;

      m_sel    = side_ff ? my_ff : mx_ff;
      p_sel    = side_ff ? py : px;
      neg_sel  = side_ff ? ry_ff[28] : rx_ff[28];
      mag_sel  = side_ff ? mag_ry : mag_rx;
      m_ext    = {{9{m_sel[10]}}, m_sel};
      num_calc = (m_ext <<< 8) - $signed({5'b0, p_sel}) + (neg_sel ? 20'sd256 : 20'sd0);

      if (rdz_ff) begin
         line_calc = 12'd0;
      end else if (num_ff == 20'sd0) begin
         line_calc = LINE_MAX;
      end else if (div_quo > DIV_W'(LINE_MAX)) begin
         line_calc = LINE_MAX;
      end else begin
         line_calc = div_quo[11:0];
      end

      dtop  = $signed({2'b0, height_ff}) - $signed({1'b0, line_ff});
      dtop1 = dtop + 13'sd1;
      top_v = (dtop[12] || dtop == 13'sd0) ? 11'd0 : dtop1[11:1];
      top_c = (top_v > height_ff) ? height_ff : top_v;
      bsum  = {3'b0, height_ff} + {2'b0, line_ff} + 14'd1;
      bv    = bsum[13:1];
      bot_c = (bv > {2'b0, height_ff}) ? height_ff : bv[10:0];
   end

   always_ff @(posedge clock) begin
      case (cmd)
         OP_LOAD: begin
            col_ff <= req_column;
            hit_ff <= 1'b0;
         end
         OP_CAM_SAVE: cam_ff <= $signed({1'b0, div_quo[24:0]}) - 26'sd16384;
         OP_RAY_MUL: begin
            prodx_ff <= plane_x_ff * cam_ff;
            prody_ff <= plane_y_ff * cam_ff;
         end
         OP_RAY_ADD: begin
            rx_ff <= {{13{dir_x_ff[15]}}, dir_x_ff} + tx[28:0];
            ry_ff <= {{13{dir_y_ff[15]}}, dir_y_ff} + ty[28:0];
         end
         OP_DX_SAVE: dx_ff <= (mag_rx == 28'd0) ? DELTA_MAX : {11'b0, div_quo};
         OP_DY_SAVE: dy_ff <= (mag_ry == 28'd0) ? DELTA_MAX : {11'b0, div_quo};
         OP_SD_INIT: begin
            sdx_ff      <= {2'b0, mulx};
            sdy_ff      <= {2'b0, muly};
            mx_ff       <= {4'b0, px[14:8]};
            my_ff       <= {4'b0, py[14:8]};
            step_cnt_ff <= '0;
         end
         OP_STEP: begin
            step_cnt_ff <= step_cnt_ff + 1'b1;
            // ties step in y
            if (sdx_ff < sdy_ff) begin
               sdx_ff  <= sdx_ff + {11'b0, dx_ff};
               mx_ff   <= mx_ff + (rx_ff[28] ? -11'sd1 : 11'sd1);
               side_ff <= 1'b0;
            end else begin
               sdy_ff  <= sdy_ff + {11'b0, dy_ff};
               my_ff   <= my_ff + (ry_ff[28] ? -11'sd1 : 11'sd1);
               side_ff <= 1'b1;
            end
         end
         OP_HIT: begin
            hit_ff  <= 1'b1;
            wall_ff <= ram_rdata;
         end
         OP_LH_MUL: begin
            num_ff <= num_calc;
            hn_ff  <= height_ff * mag_sel;
            rdz_ff <= (mag_sel == 28'd0);
         end
         OP_LH_SAVE: line_ff <= line_calc;
         OP_EMIT: begin
            if (hit_ff) begin
               rsp_ff <= {bot_c, top_c, line_ff, color_of(wall_ff), wall_ff, side_ff,
                          1'b1, col_ff};
            end else begin
               rsp_ff <= {46'b0, col_ff};
            end
         end
         default: ;
      endcase
   end

   assign stat.req_cast = req_cast;
   assign stat.div_done = div_done;
   assign stat.oob      = mx_ff[10] || my_ff[10] ||
                          (int'(mx_ff[9:0]) >= MAP_SIZE) || (int'(my_ff[9:0]) >= MAP_SIZE);
   assign stat.wall     = (ram_rdata != CHAR_SPACE);
   assign stat.limit    = (step_cnt_ff == SCW'(STEP_LIMIT));

   assign rsp_tdata = rsp_ff;
endmodule

// ===== src/grdc_ctrl.sv =====
`include "grid_ray_dda_column_caster_defines.svh"

module grdc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  grdc_pkg::dp_stat_type stat,
   output grdc_pkg::op_type      cmd
);
   import grdc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd = OP_LOAD;
               if (stat.req_cast) begin
                  state_in = ST_CAM_WAIT;
               end
            end
         end
         ST_CAM_WAIT: begin
            if (stat.div_done) begin
               cmd      = OP_CAM_SAVE;
               state_in = ST_RAY_MUL;
            end
         end
         ST_RAY_MUL: begin
            cmd      = OP_RAY_MUL;
            state_in = ST_RAY_ADD;
         end
         ST_RAY_ADD: begin
            cmd      = OP_RAY_ADD;
            state_in = ST_DX_START;
         end
         ST_DX_START: begin
            cmd      = OP_DX_START;
            state_in = ST_DX_WAIT;
         end
         ST_DX_WAIT: begin
            if (stat.div_done) begin
               cmd      = OP_DX_SAVE;
               state_in = ST_DY_WAIT;
            end
         end
         ST_DY_WAIT: begin
            if (stat.div_done) begin
               cmd      = OP_DY_SAVE;
               state_in = ST_SD_INIT;
            end
         end
         ST_SD_INIT: begin
            cmd      = OP_SD_INIT;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd      = OP_STEP;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            // drop out without a hit when the step left the map
            state_in = stat.oob ? ST_EMIT : ST_TEST;
         end
         ST_TEST: begin
            if (stat.wall) begin
               cmd      = OP_HIT;
               state_in = ST_LH_MUL;
            end else if (stat.limit) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_LH_MUL: begin
            cmd      = OP_LH_MUL;
            state_in = ST_LH_START;
         end
         ST_LH_START: begin
            cmd      = OP_LH_START;
            state_in = ST_LH_WAIT;
         end
         ST_LH_WAIT: begin
            if (stat.div_done) begin
               cmd      = OP_LH_SAVE;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd      = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd == OP_EMIT) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `GRDC_ASSERT_IMP(a_test_follows_addr, state_ff == ST_TEST, $past(state_ff) == ST_ADDR, "map test without address cycle")
   `GRDC_ASSERT_NXT(a_emit_sets_valid, cmd == OP_EMIT, rsp_valid_ff, "result transfer not offered after emit")
   `GRDC_ASSERT_IMP(a_div_done_in_wait, stat.div_done, state_ff == ST_CAM_WAIT || state_ff == ST_DX_WAIT || state_ff == ST_DY_WAIT || state_ff == ST_LH_WAIT, "divider finished outside a wait state")
endmodule
